@@ hdl/sha_pkg.sv @@
`timescale 1ns / 1ps

package sha_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned FillW  = 6;
  localparam int unsigned RndW   = 6;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned Words  = 8;
  localparam int unsigned WinLen = 16;

  localparam logic [FillW-1:0] FILL_LAST = 6'd63;
  localparam logic [FillW-1:0] LEN_POS   = 6'd56;
  localparam logic [RndW-1:0]  RND_LAST  = 6'd63;
  localparam logic [IdxW-1:0]  IDX_LAST  = 3'd7;
  localparam logic [7:0]       PAD_MARK  = 8'h80;

  localparam logic [1:0] OP_ABSORB     = 2'd0;
  localparam logic [1:0] OP_ABSORB_FIN = 2'd1;
  localparam logic [1:0] OP_FINISH     = 2'd2;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic             byte_en;
    logic [7:0]       byte_val;
    logic             load;
    logic             rnd_en;
    logic [RndW-1:0]  rnd;
    logic             fold;
    logic             init;
  } ctl_t;

  localparam word_t H_INIT [Words] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  function automatic word_t big_sig0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t sml_sig0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic word_t sml_sig1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

endpackage

@@ hdl/sha_msg_sched.sv @@
`timescale 1ns / 1ps

module sha_msg_sched (
  input  logic          clk_i,
  input  sha_pkg::ctl_t ctl_i,
  output sha_pkg::word_t w_o
);

  sha_pkg::word_t win_q [sha_pkg::WinLen];
  sha_pkg::word_t next_w;

  assign next_w = win_q[0] + sha_pkg::sml_sig0(win_q[1]) + win_q[9]
                + sha_pkg::sml_sig1(win_q[14]);

  always_ff @(posedge clk_i) begin
    if (ctl_i.byte_en) begin
      for (int j = 0; j < sha_pkg::WinLen - 1; j++) begin
        win_q[j] <= {win_q[j][23:0], win_q[j+1][31:24]};
      end
      win_q[sha_pkg::WinLen-1] <= {win_q[sha_pkg::WinLen-1][23:0], ctl_i.byte_val};
    end else if (ctl_i.rnd_en) begin
      for (int j = 0; j < sha_pkg::WinLen - 1; j++) begin
        win_q[j] <= win_q[j+1];
      end
      win_q[sha_pkg::WinLen-1] <= next_w;
    end
  end

  assign w_o = win_q[0];

endmodule

@@ hdl/sha_round.sv @@
`timescale 1ns / 1ps

module sha_round (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sha_pkg::ctl_t  ctl_i,
  input  sha_pkg::word_t w_i,
  output sha_pkg::word_t chain_o [sha_pkg::Words]
);

  sha_pkg::word_t chain_q [sha_pkg::Words];
  sha_pkg::word_t st_q    [sha_pkg::Words];
  sha_pkg::word_t t1, t2, ch, maj;

  assign ch  = (st_q[4] & st_q[5]) ^ (~st_q[4] & st_q[6]);
  assign maj = (st_q[0] & st_q[1]) ^ (st_q[0] & st_q[2]) ^ (st_q[1] & st_q[2]);
  assign t1  = st_q[7] + sha_pkg::big_sig1(st_q[4]) + ch
             + sha_pkg::ROUND_K[ctl_i.rnd] + w_i;
  assign t2  = sha_pkg::big_sig0(st_q[0]) + maj;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      st_q <= chain_q;
    end else if (ctl_i.rnd_en) begin
      st_q[0] <= t1 + t2;
      st_q[1] <= st_q[0];
      st_q[2] <= st_q[1];
      st_q[3] <= st_q[2];
      st_q[4] <= st_q[3] + t1;
      st_q[5] <= st_q[4];
      st_q[6] <= st_q[5];
      st_q[7] <= st_q[6];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= sha_pkg::H_INIT;
    end else if (ctl_i.init) begin
      chain_q <= sha_pkg::H_INIT;
    end else if (ctl_i.fold) begin
      for (int j = 0; j < sha_pkg::Words; j++) begin
        chain_q[j] <= chain_q[j] + st_q[j];
      end
    end
  end

  assign chain_o = chain_q;

endmodule

@@ hdl/sha256_stream_hasher.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Handshake                  Payload
// in       request    in_valid_i / in_ready_o    op_i, data_byte_i
// out      result     out_valid_o / out_ready_i  digest_word_o, word_index_o, last_o
//
// A byte request is accepted while idle; the 64th byte of a block keeps it busy for
// 64 rounds of the shared round unit and one fold into the chaining words.
// A finish injects pad bytes one per cycle up to the block end (one or two blocks,
// each again hashed by the rounds and a fold), then offers the eight digest words.
// Reset restores the initial hash values and clears the byte and bit counts.
// in_ready_o is high only while idle; digest words wait for out_ready_i.

module sha256_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_FOLD  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]                 state_q, state_d;
  logic [sha_pkg::FillW-1:0]  fill_q, fill_d;
  logic [63:0]                bits_q, bits_d;
  logic [sha_pkg::RndW-1:0]   rnd_q, rnd_d;
  logic [sha_pkg::IdxW-1:0]   idx_q, idx_d;
  logic                       fin_q, fin_d;
  logic                       mark_q, mark_d;
  logic                       lenok_q, lenok_d;
  logic                       lastblk_q, lastblk_d;
  logic [7:0]                 len_byte;
  sha_pkg::ctl_t              ctl;
  sha_pkg::word_t             w;
  sha_pkg::word_t             chain [sha_pkg::Words];

  assign len_byte = 8'(bits_q >> {~fill_q[2:0], 3'b000});

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    bits_d    = bits_q;
    rnd_d     = rnd_q;
    idx_d     = idx_q;
    fin_d     = fin_q;
    mark_d    = mark_q;
    lenok_d   = lenok_q;
    lastblk_d = lastblk_q;
    ctl       = '0;
    ctl.rnd   = rnd_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (op_i)
            sha_pkg::OP_ABSORB, sha_pkg::OP_ABSORB_FIN: begin
              ctl.byte_en  = 1'b1;
              ctl.byte_val = data_byte_i;
              bits_d       = bits_q + 64'd8;
              fill_d       = fill_q + 1'b1;
              fin_d        = (op_i == sha_pkg::OP_ABSORB_FIN);
              if (fill_q == sha_pkg::FILL_LAST) begin
                ctl.load = 1'b1;
                rnd_d    = '0;
                state_d  = ST_ROUND;
              end else if (op_i == sha_pkg::OP_ABSORB_FIN) begin
                state_d = ST_PAD;
              end
            end
            sha_pkg::OP_FINISH: begin
              fin_d   = 1'b1;
              state_d = ST_PAD;
            end
            default: ;
          endcase
        end
      end
      ST_PAD: begin
        ctl.byte_en = 1'b1;
        fill_d      = fill_q + 1'b1;
        if (!mark_q) begin
          ctl.byte_val = sha_pkg::PAD_MARK;
          mark_d       = 1'b1;
          lenok_d      = (fill_q < sha_pkg::LEN_POS);
        end else if (lenok_q && fill_q >= sha_pkg::LEN_POS) begin
          ctl.byte_val = len_byte;
        end else begin
          ctl.byte_val = '0;
        end
        if (fill_q == sha_pkg::FILL_LAST) begin
          ctl.load  = 1'b1;
          rnd_d     = '0;
          lenok_d   = 1'b1;
          lastblk_d = mark_q && lenok_q;
          state_d   = ST_ROUND;
        end
      end
      ST_ROUND: begin
        ctl.rnd_en = 1'b1;
        rnd_d      = rnd_q + 1'b1;
        if (rnd_q == sha_pkg::RND_LAST) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        ctl.fold = 1'b1;
        if (!fin_q) begin
          state_d = ST_IDLE;
        end else if (lastblk_q) begin
          idx_d   = '0;
          state_d = ST_OUT;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == sha_pkg::IDX_LAST) begin
            ctl.init  = 1'b1;
            fill_d    = '0;
            bits_d    = '0;
            fin_d     = 1'b0;
            mark_d    = 1'b0;
            lenok_d   = 1'b0;
            lastblk_d = 1'b0;
            state_d   = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      bits_q    <= '0;
      rnd_q     <= '0;
      idx_q     <= '0;
      fin_q     <= 1'b0;
      mark_q    <= 1'b0;
      lenok_q   <= 1'b0;
      lastblk_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      bits_q    <= bits_d;
      rnd_q     <= rnd_d;
      idx_q     <= idx_d;
      fin_q     <= fin_d;
      mark_q    <= mark_d;
      lenok_q   <= lenok_d;
      lastblk_q <= lastblk_d;
    end
  end

  sha_msg_sched u_sched (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .w_o   (w)
  );

  sha_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .w_i     (w),
    .chain_o (chain)
  );

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_OUT);
  assign digest_word_o = chain[idx_q];
  assign word_index_o  = idx_q;
  assign last_o        = (idx_q == sha_pkg::IDX_LAST);

endmodule
